[hw/rtl/tsc_pkg.sv]
// tsc_pkg: widths, fixed-point constants and the sideband type of the
// taylor sine/cosine pipeline; used by every module of the block
package tsc_pkg;

    localparam int AW        = 26;
    localparam int VW        = 32;
    localparam int XW        = 44;
    localparam int XH        = XW / 2;
    localparam int TW        = 54;
    localparam int TH        = TW / 2;
    localparam int SW        = TW + 1;
    localparam int MW        = 62;
    localparam int MH        = MW / 2;
    localparam int KW        = 55;
    localparam int KL        = 28;
    localparam int KH        = KW - KL;
    localparam int FRAC      = 40;
    localparam int XSHIFT    = 60 + 16 - FRAC;
    localparam int DIV_SHIFT = 61;
    localparam int OUT_SHIFT = FRAC - 30;

    localparam logic [63:0]   PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [KW-1:0] DEG2RAD = KW'((PI_Q60 + 64'd90) / 64'd180);

    localparam logic [VW-1:0] SAT_POS = 32'h7FFFFFFF;
    localparam logic [VW-1:0] SAT_NEG = 32'h80000000;

    typedef struct packed {
        logic                 kind;
        logic                 flip;
        logic [XW-1:0]        x;
        logic signed [SW-1:0] sum;
    } t_side;

endpackage

[hw/rtl/tsc_front.sv]
// tsc_front: input register, angle magnitude and degree to radian scaling,
// first series term; three stages, depends on tsc_pkg
module tsc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_vld,
    input  logic                            i_kind,
    input  logic signed [tsc_pkg::AW-1:0]   i_angle,
    output logic                            o_vld,
    output tsc_pkg::t_side                  o_side,
    output logic [tsc_pkg::TW-1:0]          o_t
);
    import tsc_pkg::*;

    localparam int FW = AW + KW;

    logic                 r_vld1, r_vld2, r_vld3;
    logic                 r_kind1, r_kind2, r_flip2;
    logic [AW-1:0]        r_raw1;
    logic [AW+KL-1:0]     r_pp_lo;
    logic [AW+KH-1:0]     r_pp_hi;
    t_side                r_side3;
    logic [TW-1:0]        r_t3;

    logic                 neg;
    logic [AW-1:0]        mag;
    logic [FW-1:0]        xs;
    logic [XW-1:0]        x;

    assign neg = r_raw1[AW-1];
    assign mag = neg ? (AW'(0) - r_raw1) : r_raw1;
    assign xs  = (FW'(r_pp_hi) << KL) + FW'(r_pp_lo) + (FW'(1) << (XSHIFT - 1));
    assign x   = xs[XSHIFT +: XW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind1      <= i_kind;
            r_raw1       <= i_angle;
            r_kind2      <= r_kind1;
            r_flip2      <= r_kind1 & neg;
            r_pp_lo      <= (AW+KL)'(mag) * (AW+KL)'(DEG2RAD[KL-1:0]);
            r_pp_hi      <= (AW+KH)'(mag) * (AW+KH)'(DEG2RAD[KW-1:KL]);
            r_side3.kind <= r_kind2;
            r_side3.flip <= r_flip2;
            r_side3.x    <= x;
            r_side3.sum  <= '0;
            r_t3         <= r_kind2 ? TW'(x) : (TW'(1) << FRAC);
        end
    end

    assign o_vld  = r_vld3;
    assign o_side = r_side3;
    assign o_t    = r_t3;

endmodule

[hw/rtl/tsc_mulx.sv]
// tsc_mulx: term times angle in radians, rounded back to Q40; two stages
// (partial products, then sum and round), depends on tsc_pkg
module tsc_mulx (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  tsc_pkg::t_side          i_side,
    input  logic [tsc_pkg::TW-1:0]  i_t,
    output logic                    o_vld,
    output tsc_pkg::t_side          o_side,
    output logic [tsc_pkg::TW-1:0]  o_t
);
    import tsc_pkg::*;

    localparam int PPW = TH + XH;
    localparam int PW  = TW + XW;

    logic            r_vld1, r_vld2;
    t_side           r_side1, r_side2;
    logic [PPW-1:0]  r_pp_ll, r_pp_lh, r_pp_hl, r_pp_hh;
    logic [TW-1:0]   r_t2;
    logic [PW-1:0]   prod_sum;

    assign prod_sum = (PW'(r_pp_hh) << (TH + XH)) + (PW'(r_pp_hl) << TH)
                    + (PW'(r_pp_lh) << XH) + PW'(r_pp_ll) + (PW'(1) << (FRAC - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= i_side;
            r_pp_ll <= PPW'(i_t[TH-1:0])  * PPW'(i_side.x[XH-1:0]);
            r_pp_lh <= PPW'(i_t[TH-1:0])  * PPW'(i_side.x[XW-1:XH]);
            r_pp_hl <= PPW'(i_t[TW-1:TH]) * PPW'(i_side.x[XH-1:0]);
            r_pp_hh <= PPW'(i_t[TW-1:TH]) * PPW'(i_side.x[XW-1:XH]);
            r_side2 <= r_side1;
            r_t2    <= prod_sum[FRAC +: TW];
        end
    end

    assign o_vld  = r_vld2;
    assign o_side = r_side2;
    assign o_t    = r_t2;

endmodule

[hw/rtl/tsc_divc.sv]
// tsc_divc: rounded division of a term by a factorial factor, done as a
// multiply by a ceiling-rounded reciprocal; two stages, depends on tsc_pkg
module tsc_divc #(
    parameter int DIV_COS = 1,
    parameter int DIV_SIN = 2
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_vld,
    input  tsc_pkg::t_side          i_side,
    input  logic [tsc_pkg::TW-1:0]  i_t,
    output logic                    o_vld,
    output tsc_pkg::t_side          o_side,
    output logic [tsc_pkg::TW-1:0]  o_t
);
    import tsc_pkg::*;

    localparam int PPW = TH + MH;
    localparam int PW  = TW + MW;

    localparam logic [63:0]   Scale   = 64'd1 << DIV_SHIFT;
    localparam logic [MW-1:0] MagCos  = MW'((Scale + 64'(DIV_COS) - 64'd1) / 64'(DIV_COS));
    localparam logic [MW-1:0] MagSin  = MW'((Scale + 64'(DIV_SIN) - 64'd1) / 64'(DIV_SIN));
    localparam logic [MW-1:0] HalfCos = MW'(64'(DIV_COS / 2) * 64'(MagCos));
    localparam logic [MW-1:0] HalfSin = MW'(64'(DIV_SIN / 2) * 64'(MagSin));

    logic            r_vld1, r_vld2;
    t_side           r_side1, r_side2;
    logic [PPW-1:0]  r_pp_ll, r_pp_lh, r_pp_hl, r_pp_hh;
    logic [TW-1:0]   r_t2;
    logic [MW-1:0]   mag;
    logic [MW-1:0]   half;
    logic [PW-1:0]   prod_sum;

    assign mag      = i_side.kind ? MagSin : MagCos;
    assign half     = r_side1.kind ? HalfSin : HalfCos;
    assign prod_sum = (PW'(r_pp_hh) << (TH + MH)) + (PW'(r_pp_hl) << TH)
                    + (PW'(r_pp_lh) << MH) + PW'(r_pp_ll) + PW'(half);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side1 <= i_side;
            r_pp_ll <= PPW'(i_t[TH-1:0])  * PPW'(mag[MH-1:0]);
            r_pp_lh <= PPW'(i_t[TH-1:0])  * PPW'(mag[MW-1:MH]);
            r_pp_hl <= PPW'(i_t[TW-1:TH]) * PPW'(mag[MH-1:0]);
            r_pp_hh <= PPW'(i_t[TW-1:TH]) * PPW'(mag[MW-1:MH]);
            r_side2 <= r_side1;
            r_t2    <= prod_sum[DIV_SHIFT +: TW];
        end
    end

    assign o_vld  = r_vld2;
    assign o_side = r_side2;
    assign o_t    = r_t2;

endmodule

[hw/rtl/taylor_sine_cosine_top.sv]
// taylor_sine_cosine_top: degree angle in, Q2.30 sine or cosine out
// throughput: one beat per cycle while the two-entry skid buffer is not full;
// 3 front stages, 8 stages per extra term, 3 output stages and a two-entry
// skid buffer that sets o_ready (low when both entries are held)
// reset: synchronous active-low i_rst_n clears all valid bits and the skid
// buffer; depends on tsc_pkg, tsc_front, tsc_mulx, tsc_divc
module taylor_sine_cosine_top #(
    parameter int TERMS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_kind,
    input  logic signed [tsc_pkg::AW-1:0]   i_angle_degrees,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [tsc_pkg::VW-1:0]   o_value
);
    import tsc_pkg::*;

    localparam logic LastSub = ((TERMS - 1) % 2) == 1;
    localparam int   RW      = SW - OUT_SHIFT;

    logic              en;
    logic              push, pop;

    logic              c_vld  [0:TERMS-1];
    t_side             c_side [0:TERMS-1];
    logic [TW-1:0]     c_t    [0:TERMS-1];

    logic                 r_vld_e0, r_vld_e1, r_vld_e2;
    logic                 r_flip_e0, r_neg_e1;
    logic signed [SW-1:0] r_sum_e0;
    logic [TW-1:0]        r_mag_e1;
    logic [VW-1:0]        r_val_e2;
    logic [1:0]           r_cnt, n_cnt;
    logic [VW-1:0]        r_head, r_tail;

    logic signed [SW-1:0] last_ext;
    logic [SW-1:0]        abs_sum;
    logic [SW-1:0]        rnd_sum;
    logic [RW-1:0]        rnd;
    logic [VW-1:0]        clip;

    assign en      = (r_cnt != 2'd2);
    assign o_ready = en;
    assign push    = en & r_vld_e2;
    assign pop     = o_valid & i_ready;

    tsc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_valid),
        .i_kind  (i_kind),
        .i_angle (i_angle_degrees),
        .o_vld   (c_vld[0]),
        .o_side  (c_side[0]),
        .o_t     (c_t[0])
    );

    for (genvar i = 1; i < TERMS; i++) begin : g_term
        localparam logic Sub = (i % 2) == 0;

        t_side          s_in;
        logic           v_a, v_b, v_c;
        t_side          s_a, s_b, s_c;
        logic [TW-1:0]  t_a, t_b, t_c;
        logic signed [SW-1:0] t_ext;

        always_comb begin
            t_ext    = $signed({1'b0, c_t[i-1]});
            s_in     = c_side[i-1];
            s_in.sum = Sub ? (c_side[i-1].sum - t_ext) : (c_side[i-1].sum + t_ext);
        end

        tsc_mulx u_mx1 (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_vld (c_vld[i-1]), .i_side (s_in), .i_t (c_t[i-1]),
            .o_vld (v_a), .o_side (s_a), .o_t (t_a)
        );

        tsc_divc #(.DIV_COS(2 * i - 1), .DIV_SIN(2 * i)) u_dv1 (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_vld (v_a), .i_side (s_a), .i_t (t_a),
            .o_vld (v_b), .o_side (s_b), .o_t (t_b)
        );

        tsc_mulx u_mx2 (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_vld (v_b), .i_side (s_b), .i_t (t_b),
            .o_vld (v_c), .o_side (s_c), .o_t (t_c)
        );

        tsc_divc #(.DIV_COS(2 * i), .DIV_SIN(2 * i + 1)) u_dv2 (
            .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
            .i_vld (v_c), .i_side (s_c), .i_t (t_c),
            .o_vld (c_vld[i]), .o_side (c_side[i]), .o_t (c_t[i])
        );
    end

    // final accumulate, sign fold, round and saturate
    assign last_ext = $signed({1'b0, c_t[TERMS-1]});
    assign abs_sum  = r_sum_e0[SW-1] ? (SW'(0) - SW'(r_sum_e0)) : SW'(r_sum_e0);
    assign rnd_sum  = SW'(r_mag_e1) + (SW'(1) << (OUT_SHIFT - 1));
    assign rnd      = rnd_sum[SW-1:OUT_SHIFT];

    always_comb begin
        if (r_neg_e1) begin
            clip = (rnd > RW'(SAT_NEG)) ? SAT_NEG : rnd[VW-1:0];
        end else begin
            clip = (rnd > RW'(SAT_POS)) ? SAT_POS : rnd[VW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_e0 <= 1'b0;
            r_vld_e1 <= 1'b0;
            r_vld_e2 <= 1'b0;
        end else if (en) begin
            r_vld_e0 <= c_vld[TERMS-1];
            r_vld_e1 <= r_vld_e0;
            r_vld_e2 <= r_vld_e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum_e0  <= LastSub ? (c_side[TERMS-1].sum - last_ext)
                                 : (c_side[TERMS-1].sum + last_ext);
            r_flip_e0 <= c_side[TERMS-1].flip;
            r_neg_e1  <= r_flip_e0 ? (r_sum_e0 > 0) : (r_sum_e0 < 0);
            r_mag_e1  <= abs_sum[TW-1:0];
            r_val_e2  <= r_neg_e1 ? (VW'(0) - clip) : clip;
        end
    end

    // two-entry skid buffer
    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (push) begin
                r_head <= r_val_e2;
            end else begin
                r_head <= r_tail;
            end
        end else if (push) begin
            if (r_cnt == 2'd0) begin
                r_head <= r_val_e2;
            end else begin
                r_tail <= r_val_e2;
            end
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_value = $signed(r_head);

endmodule

[dv/tb_top.sv]
// tb_top: self-checking bench for taylor_sine_cosine_top, degree angle in, Q2.30 value out
// holds a bit-exact fixed-point series predictor, a queued driver and a checking monitor
// depends on tsc_pkg and the taylor_sine_cosine_top rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsc_pkg::*;

    localparam int    N_TERMS      = 16;
    localparam int    N_RANDOM     = 1300;
    localparam int    QUIET_TAIL   = 150;
    localparam int    DRAIN_CYCLES = 8 * N_TERMS + 64;
    localparam int    STALL_LIMIT  = 4000;
    localparam logic  KIND_COS     = 1'b0;
    localparam logic  KIND_SIN     = 1'b1;
    localparam int    DEG_360      = 360 * 65536;
    localparam logic [63:0] RAD_PER_DEG = (PI_Q60 + 64'd90) / 64'd180;

    typedef struct packed {
        logic              kind;
        logic signed [AW-1:0] angle;
    } t_angle_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_kind = KIND_COS;
    logic signed [AW-1:0]  i_angle_degrees = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic signed [VW-1:0]  o_value;

    t_angle_beat   angle_queue[$];
    logic [VW-1:0] value_queue[$];
    int            n_errors = 0;
    int            n_total = 0;
    int            n_sent = 0;
    int            tx_gap = 0;
    int            rx_gap = 0;
    int            tx_pct = 0;
    int            rx_pct = 0;
    int            stall_cnt = 0;
    logic          tx_next;
    logic          rx_next;
    t_angle_beat   tx_beat;
    logic [VW-1:0] want;

    taylor_sine_cosine_top #(.TERMS(N_TERMS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_angle_degrees (i_angle_degrees),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_value         (o_value)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (s - 1));
        return 64'(p >> s);
    endfunction

    function automatic logic [63:0] div_round(input logic [63:0] v, input logic [63:0] d);
        return (v + d / 64'd2) / d;
    endfunction

    function automatic logic [VW-1:0] series_value(input logic kind,
                                                   input logic signed [AW-1:0] deg);
        logic        neg_in;
        logic        neg_out;
        logic [63:0] mag;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] n;
        logic [63:0] acc;
        logic [63:0] m;
        logic [63:0] r;
        neg_in = deg[AW-1];
        mag = neg_in ? (64'd1 << AW) - {{(64-AW){1'b0}}, deg} : {{(64-AW){1'b0}}, deg};
        x = mul_round(mag, RAD_PER_DEG, XSHIFT);
        if (kind == KIND_COS) begin
            t = 64'd1 << FRAC;
            n = 64'd0;
        end else begin
            t = x;
            n = 64'd1;
        end
        acc = '0;
        for (int i = 0; i < N_TERMS; i++) begin
            if (i % 2 == 0) acc = acc + t;
            else acc = acc - t;
            t = mul_round(t, x, FRAC);
            t = div_round(t, n + 64'd1);
            t = mul_round(t, x, FRAC);
            t = div_round(t, n + 64'd2);
            n = n + 64'd2;
        end
        if (kind == KIND_SIN && neg_in) acc = -acc;
        neg_out = acc[63];
        m = neg_out ? -acc : acc;
        r = (m + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (neg_out) begin
            if (r > {32'd0, SAT_NEG}) r = {32'd0, SAT_NEG};
            return VW'(64'd0 - r);
        end
        if (r > {32'd0, SAT_POS}) r = {32'd0, SAT_POS};
        return VW'(r);
    endfunction

    function automatic logic signed [AW-1:0] random_angle();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            v = $urandom_range(0, 2 * DEG_360) - DEG_360;
        end else if (sel < 80) begin
            v = $urandom();
        end else if (sel < 90) begin
            v = ($urandom_range(0, 8) - 4) * 90 * 65536 + $urandom_range(0, 6) - 3;
        end else begin
            v = $urandom_range(0, 255);
            if ($urandom_range(0, 1)) v = -v;
        end
        return AW'(v);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            tx_next = i_valid;
            if (i_valid && o_ready) begin
                value_queue.push_back(series_value(i_kind, i_angle_degrees));
                n_sent++;
                tx_next = 1'b0;
                if (n_sent % 64 == 0) tx_pct = pick_pct();
                if (n_sent >= n_total - QUIET_TAIL) tx_pct = 0;
            end
            if (!tx_next) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (angle_queue.size() > 0) begin
                    if (tx_pct > 0 && $urandom_range(0, 99) < tx_pct) begin
                        tx_gap = $urandom_range(1, 7) - 1;
                    end else begin
                        tx_beat = angle_queue.pop_front();
                        i_kind <= tx_beat.kind;
                        i_angle_degrees <= tx_beat.angle;
                        tx_next = 1'b1;
                    end
                end
            end
            i_valid <= tx_next;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (value_queue.size() == 0) begin
                    $error("value: unexpected beat, actual %h", o_value);
                    n_errors++;
                end else begin
                    want = value_queue.pop_front();
                    if (o_value !== want) begin
                        $error("value: expected %h, actual %h", want, o_value);
                        n_errors++;
                    end
                end
            end
            if (n_sent % 64 == 0) rx_pct = pick_pct();
            if (n_sent >= n_total - QUIET_TAIL) rx_pct = 0;
            if (rx_gap > 0) begin
                rx_gap--;
                rx_next = 1'b0;
            end else if (rx_pct > 0 && $urandom_range(0, 99) < rx_pct) begin
                rx_gap = $urandom_range(1, 7) - 1;
                rx_next = 1'b0;
            end else begin
                rx_next = 1'b1;
            end
            i_ready <= rx_next;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cnt = 0;
            else stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        int dir_deg[12];
        t_angle_beat b;
        dir_deg = '{0, 1, -1, 30 * 65536, 45 * 65536, 90 * 65536, -90 * 65536,
                    180 * 65536, DEG_360, -DEG_360, (1 << (AW - 1)) - 1, -(1 << (AW - 1))};
        foreach (dir_deg[j]) begin
            b.kind = KIND_COS;
            b.angle = AW'(dir_deg[j]);
            angle_queue.push_back(b);
            b.kind = KIND_SIN;
            angle_queue.push_back(b);
        end
        for (int j = 0; j < N_RANDOM; j++) begin
            b.kind = $urandom_range(0, 1) ? KIND_SIN : KIND_COS;
            b.angle = random_angle();
            angle_queue.push_back(b);
        end
        n_total = angle_queue.size();
        tx_pct = pick_pct();
        rx_pct = pick_pct();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (angle_queue.size() > 0 || i_valid) @(posedge i_clk);
        while (value_queue.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (value_queue.size() > 0) begin
            $error("value: %0d beats never arrived", value_queue.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/tsc_pkg.sv
hw/rtl/tsc_front.sv
hw/rtl/tsc_mulx.sv
hw/rtl/tsc_divc.sv
hw/rtl/taylor_sine_cosine_top.sv
dv/tb_top.sv
